// ----- rtl/hgcd_pkg.sv -----
package hgcd_pkg;

    // Reset value of the radius register: 6371.008771 km in units of 2^-16 km.
    localparam logic [31:0] RADIUS_RESET = 32'd417530431;

    // Bias that keeps every angle numerator positive: 90 * 2^40 plus the
    // rounding offset of 45. A multiple of 90 times 2^40 does not change the
    // low 32 bits of the quotient.
    localparam logic [47:0] NUM_BIAS = 48'd98956046499885;

    // Division by 90 is done as a halving followed by a division by 45.
    // RECIP45 is ceil(2^20 / 45), exact for the small remainder sums, and
    // INV45 is the inverse of 45 modulo 2^32.
    localparam logic [5:0]  MOD_BASE = 6'd45;
    localparam logic [14:0] RECIP45  = 15'd23302;
    localparam logic [31:0] INV45    = 32'd2767867813;

    localparam int          NITER    = 30;

    // Rotation start vector, which cancels the CORDIC gain.
    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] PI_Q29  = 31'd1686629713;

    // atan(2^-i) in binary angle units, 2^32 per full turn.
    localparam logic [29:0] ATAN_TAB [NITER] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,         30'd3,        30'd1
    };

    typedef logic signed [32:0] t_rot;
    typedef logic signed [31:0] t_q30;
    typedef logic signed [33:0] t_vec;

    typedef struct packed {
        t_rot x;
        t_rot y;
        t_rot z;
        logic flip;
    } t_rot_st;

    typedef struct packed {
        logic [61:0] n;
        logic [32:0] rem;
        logic [30:0] root;
    } t_sqrt_st;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_vec z;
    } t_vec_st;

endpackage

// ----- rtl/haversine_great_circle_distance.sv -----
// Haversine great-circle distance, fully pipelined. One coordinate pair is
// accepted per clock cycle and one distance comes out per cycle, as long as
// the output buffer has a free entry. The pipe is a chain of pipelined
// units: a six-stage division by 90 built from a chunked remainder and a
// modular inverse multiply, which turns degrees into binary angles, a
// 30-stage sine/cosine CORDIC, a 31-stage square root and a 30-stage atan2
// CORDIC, each stage one step. A two-entry output buffer sits behind the
// pipe, so the input keeps taking beats while a result waits; only when both
// entries are full does the whole pipe hold, and it then freezes in place
// without dropping or repeating a beat. The radius register is read at the
// last multiply and must only be written while no beat is in flight.
module haversine_great_circle_distance (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: sphere radius in units of 2^-16 km.
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    // Input stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // From bit 0: first_latitude[30:0], first_longitude[62:31],
    // second_latitude[93:63], second_longitude[125:94], zero pad[127:126].
    input  logic [127:0] i_s_axis_tdata,
    // Output stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // From bit 0: distance[31:0].
    output logic [31:0]  o_m_axis_tdata
);

    localparam int DIV_STG  = 6;
    localparam int SQRT_STG = 31;
    // Numerators, division, rotation, flip, two multiplies, clamp, square
    // root, vectoring and three output stages.
    localparam int NSTG = 1 + DIV_STG + 1 + hgcd_pkg::NITER + 1 + 1 + 1 + 1 +
                          1 + SQRT_STG + 1 + hgcd_pkg::NITER + 3;

    // ------------------------------------------------------------------
    // Step functions for the serial units.
    // ------------------------------------------------------------------
    function automatic hgcd_pkg::t_rot_st rot_step(input hgcd_pkg::t_rot_st s,
                                                   input int i);
        hgcd_pkg::t_rot_st o;
        hgcd_pkg::t_rot    dx;
        hgcd_pkg::t_rot    dy;
        hgcd_pkg::t_rot    a;
        o  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        a  = signed'(33'(hgcd_pkg::ATAN_TAB[i]));
        if (!s.z[32]) begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - a;
        end else begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + a;
        end
        return o;
    endfunction

    function automatic hgcd_pkg::t_sqrt_st sqrt_step(input hgcd_pkg::t_sqrt_st s);
        hgcd_pkg::t_sqrt_st o;
        logic [34:0]        r;
        logic [34:0]        v;
        o = s;
        r = {s.rem, s.n[61:60]};
        v = 35'({s.root, 2'b01});
        if (r >= v) begin
            o.rem  = 33'(r - v);
            o.root = {s.root[29:0], 1'b1};
        end else begin
            o.rem  = 33'(r);
            o.root = {s.root[29:0], 1'b0};
        end
        o.n = {s.n[59:0], 2'b00};
        return o;
    endfunction

    function automatic hgcd_pkg::t_vec_st vec_step(input hgcd_pkg::t_vec_st s,
                                                   input int i);
        hgcd_pkg::t_vec_st o;
        hgcd_pkg::t_vec    dx;
        hgcd_pkg::t_vec    dy;
        hgcd_pkg::t_vec    a;
        o  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        a  = signed'(34'(hgcd_pkg::ATAN_TAB[i]));
        if (s.y > 0) begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + a;
        end else begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - a;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: the pipe advances as long as the output buffer has a
    // free entry. This is a registered condition, so ready does not depend
    // combinationally on the downstream ready.
    // ------------------------------------------------------------------
    logic [1:0]      r_cnt;
    logic            r_wptr;
    logic            r_rptr;
    logic [31:0]     r_buf [2];
    logic [NSTG-1:0] r_vld;
    logic            adv;
    logic            push;
    logic            pop;
    logic [31:0]     w_dist;

    assign adv             = (r_cnt != 2'd2);
    assign o_s_axis_tready = adv;
    assign push            = adv && r_vld[NSTG-1];
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    // Radius register.
    logic [31:0] r_radius;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hgcd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Angle numerators. Lane 0: half latitude difference, lane 1: half
    // longitude difference, lanes 2 and 3: the two latitudes. The binary
    // angle is floor((2 * deg * mul + 45) / 90) with mul 32 for the half
    // differences and 64 for plain angles.
    // ------------------------------------------------------------------
    logic signed [30:0] w_lat1;
    logic signed [31:0] w_lon1;
    logic signed [30:0] w_lat2;
    logic signed [31:0] w_lon2;
    logic signed [47:0] w_dlat;
    logic signed [47:0] w_dlon;
    logic [47:0]        w_num [4];

    assign w_lat1 = i_s_axis_tdata[30:0];
    assign w_lon1 = i_s_axis_tdata[62:31];
    assign w_lat2 = i_s_axis_tdata[93:63];
    assign w_lon2 = i_s_axis_tdata[125:94];
    assign w_dlat = 48'(w_lat2) - 48'(w_lat1);
    assign w_dlon = 48'(w_lon2) - 48'(w_lon1);

    always_comb begin
        w_num[0] = 48'(w_dlat <<< 6) + hgcd_pkg::NUM_BIAS;
        w_num[1] = 48'(w_dlon <<< 6) + hgcd_pkg::NUM_BIAS;
        w_num[2] = 48'(48'(w_lat1) <<< 7) + hgcd_pkg::NUM_BIAS;
        w_num[3] = 48'(48'(w_lat2) <<< 7) + hgcd_pkg::NUM_BIAS;
    end

    // Division by 90 in six stages. The biased numerator is halved, and the
    // half is divided by 45. Since 2^12 leaves 1 modulo 45, the remainder
    // comes from the sum of the 12-bit chunks, folded once more and reduced
    // by a small reciprocal multiply. The half minus its remainder is an
    // exact multiple of 45, so multiplying it by the inverse of 45 modulo
    // 2^32 yields the low 32 quotient bits.
    logic [47:0] r_num   [4];
    logic [13:0] r_csum  [4];
    logic [12:0] r_fsum  [4];
    logic [12:0] r_fsum3 [4];
    logic [7:0]  r_qs    [4];
    logic [5:0]  r_rem   [4];
    logic [31:0] r_diff  [4];
    logic [31:0] r_quo   [4];
    logic [31:0] r_lo    [4][4];
    logic [46:0] w_half  [4];
    logic [27:0] w_qprod [4];
    logic [12:0] w_rem   [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_half[k]  = r_num[k][47:1];
            w_qprod[k] = 28'(r_fsum[k]) * 28'(hgcd_pkg::RECIP45);
            w_rem[k]   = r_fsum3[k] - 13'(r_qs[k]) * 13'(hgcd_pkg::MOD_BASE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_num[k]   <= w_num[k];
                r_csum[k]  <= 14'(w_half[k][11:0]) + 14'(w_half[k][23:12]) +
                              14'(w_half[k][35:24]) + 14'(w_half[k][46:36]);
                r_lo[0][k] <= w_half[k][31:0];
                r_fsum[k]  <= 13'(r_csum[k][11:0]) + 13'(r_csum[k][13:12]);
                r_lo[1][k] <= r_lo[0][k];
                r_qs[k]    <= w_qprod[k][27:20];
                r_fsum3[k] <= r_fsum[k];
                r_lo[2][k] <= r_lo[1][k];
                r_rem[k]   <= w_rem[k][5:0];
                r_lo[3][k] <= r_lo[2][k];
                r_diff[k]  <= r_lo[3][k] - 32'(r_rem[k]);
                r_quo[k]   <= r_diff[k] * hgcd_pkg::INV45;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine by CORDIC rotation. The first stage folds the angle
    // into the right half plane and remembers the half-turn flip.
    // ------------------------------------------------------------------
    hgcd_pkg::t_rot_st w_fold [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_fold[k].x    = hgcd_pkg::CORDIC_START;
            w_fold[k].y    = '0;
            w_fold[k].z    = 33'(signed'(r_quo[k]));
            w_fold[k].flip = 1'b0;
            if (w_fold[k].z >= hgcd_pkg::QUARTER_TURN) begin
                w_fold[k].z    = w_fold[k].z - hgcd_pkg::HALF_TURN;
                w_fold[k].flip = 1'b1;
            end else if (w_fold[k].z < -hgcd_pkg::QUARTER_TURN) begin
                w_fold[k].z    = w_fold[k].z + hgcd_pkg::HALF_TURN;
                w_fold[k].flip = 1'b1;
            end
        end
    end

    hgcd_pkg::t_rot_st r_rot [hgcd_pkg::NITER+1][4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_rot[0][k] <= w_fold[k];
                for (int i = 0; i < hgcd_pkg::NITER; i++) begin
                    r_rot[i+1][k] <= rot_step(r_rot[i][k], i);
                end
            end
        end
    end

    // Undo the flip and keep the component each lane needs: sines of the
    // half differences, cosines of the latitudes.
    hgcd_pkg::t_q30 r_sc [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                if (k < 2) begin
                    r_sc[k] <= r_rot[hgcd_pkg::NITER][k].flip ?
                               32'(-r_rot[hgcd_pkg::NITER][k].y) :
                               32'(r_rot[hgcd_pkg::NITER][k].y);
                end else begin
                    r_sc[k] <= r_rot[hgcd_pkg::NITER][k].flip ?
                               32'(-r_rot[hgcd_pkg::NITER][k].x) :
                               32'(r_rot[hgcd_pkg::NITER][k].x);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Haversine term a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2), Q30.
    // ------------------------------------------------------------------
    logic signed [63:0] w_p_sq1;
    logic signed [63:0] w_p_sq2;
    logic signed [63:0] w_p_cc;
    logic signed [65:0] w_p_t;
    logic signed [32:0] r_sq1;
    logic signed [32:0] r_sq2;
    logic signed [32:0] r_cc;
    logic signed [32:0] r_sq1b;
    logic signed [32:0] r_t;
    logic signed [33:0] w_a_sum;
    logic [30:0]        r_a;

    assign w_p_sq1 = 64'(r_sc[0]) * 64'(r_sc[0]);
    assign w_p_sq2 = 64'(r_sc[1]) * 64'(r_sc[1]);
    assign w_p_cc  = 64'(r_sc[2]) * 64'(r_sc[3]);
    assign w_p_t   = 66'(r_cc) * 66'(r_sq2);
    assign w_a_sum = 34'(r_sq1b) + 34'(r_t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq1  <= 33'(w_p_sq1 >>> 30);
            r_sq2  <= 33'(w_p_sq2 >>> 30);
            r_cc   <= 33'(w_p_cc >>> 30);
            r_sq1b <= r_sq1;
            r_t    <= 33'(w_p_t >>> 30);
            if (w_a_sum < 0) begin
                r_a <= '0;
            end else if (w_a_sum > 34'(hgcd_pkg::ONE_Q30)) begin
                r_a <= hgcd_pkg::ONE_Q30;
            end else begin
                r_a <= 31'(w_a_sum);
            end
        end
    end

    // ------------------------------------------------------------------
    // Square roots of a and 1 - a, both scaled by 2^30, one root bit per
    // stage. Lane 0 is sqrt(a), lane 1 is sqrt(1 - a).
    // ------------------------------------------------------------------
    hgcd_pkg::t_sqrt_st r_sq [SQRT_STG+1][2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0][0].n    <= {1'b0, r_a, 30'd0};
            r_sq[0][1].n    <= {1'b0, 31'(hgcd_pkg::ONE_Q30 - r_a), 30'd0};
            r_sq[0][0].rem  <= '0;
            r_sq[0][1].rem  <= '0;
            r_sq[0][0].root <= '0;
            r_sq[0][1].root <= '0;
            for (int s = 1; s <= SQRT_STG; s++) begin
                for (int k = 0; k < 2; k++) begin
                    r_sq[s][k] <= sqrt_step(r_sq[s-1][k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // atan2(sqrt(a), sqrt(1 - a)) by CORDIC vectoring.
    // ------------------------------------------------------------------
    hgcd_pkg::t_vec_st r_vec [hgcd_pkg::NITER+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vec[0].x <= 34'(r_sq[SQRT_STG][1].root);
            r_vec[0].y <= 34'(r_sq[SQRT_STG][0].root);
            r_vec[0].z <= '0;
            for (int i = 0; i < hgcd_pkg::NITER; i++) begin
                r_vec[i+1] <= vec_step(r_vec[i], i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Central angle in Q30 radians, then distance with rounding and
    // saturation.
    // ------------------------------------------------------------------
    hgcd_pkg::t_vec w_z;
    logic [30:0]    w_zc;
    logic [61:0]    r_m;
    logic [62:0]    w_m_rnd;
    logic [31:0]    r_cr;
    logic [63:0]    r_p;
    logic [64:0]    w_p_rnd;

    assign w_z     = r_vec[hgcd_pkg::NITER].z;
    assign w_m_rnd = 63'(r_m) + 63'(64'd1 << 28);
    assign w_p_rnd = 65'(r_p) + 65'(64'd1 << 29);

    always_comb begin
        if (w_z < 0) begin
            w_zc = '0;
        end else if (w_z > 34'(hgcd_pkg::ONE_Q30)) begin
            w_zc = hgcd_pkg::ONE_Q30;
        end else begin
            w_zc = 31'(w_z);
        end
    end

    always_comb begin
        if (w_p_rnd[64:62] != 3'd0) begin
            w_dist = '1;
        end else begin
            w_dist = w_p_rnd[61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m  <= 62'(w_zc) * 62'(hgcd_pkg::PI_Q29);
            r_cr <= w_m_rnd[60:29];
            r_p  <= 64'(r_radius) * 64'(r_cr);
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The buffer never reports more than two entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // A held pipe keeps its valid pattern: nothing is lost or repeated.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // A beat leaving the last stage lands in the buffer.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_cnt != 2'd0)
        else $error("result beat did not reach the output buffer");

    // Both pointers agree when the buffer is empty or full.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wptr == r_rptr)
        else $error("output buffer pointers out of step");

endmodule

// ----- tb/haversine_great_circle_distance_tb.sv -----
`timescale 1ns / 1ps

// Scoreboard for the distance stream. It holds its own copy of the radius
// register, predicts a distance for each accepted coordinate pair and checks
// the distances that come out against the oldest prediction.
class distance_scoreboard;
    logic [31:0] radius;
    logic [31:0] pending_dist[$];
    int          n_errors;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    longint atan_steps[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    function new();
        radius = 32'd417530431;
        n_errors = 0;
    endfunction

    // Floor division by 90, then taken modulo one turn.
    function logic [31:0] binary_angle(longint deg, longint mul);
        longint num, q;
        num = 2 * deg * mul + 45;
        q = num / 90;
        if ((num % 90) < 0) q = q - 1;
        return q[31:0];
    endfunction

    // Rotation-mode CORDIC; returns sine and cosine in Q30.
    function void rotate(logic [31:0] ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(signed'(ang));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= ONE_Q30) begin
            z -= 64'sd1 << 31;
            flip = 1;
        end else if (z < -ONE_Q30) begin
            z += 64'sd1 << 31;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_steps[i];
            end else begin
                x += dx; y -= dy; z += atan_steps[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function logic [31:0] great_circle(logic signed [30:0] lat1, logic signed [31:0] lon1,
                                       logic signed [30:0] lat2,
                                       logic signed [31:0] lon2);
        longint s1, s2, c1, c2, dummy, cc, a, vx, vy, z, dx, dy;
        longint unsigned m, cr, d;
        rotate(binary_angle(longint'(lat2) - longint'(lat1), 32), s1, dummy);
        rotate(binary_angle(longint'(lon2) - longint'(lon1), 32), s2, dummy);
        rotate(binary_angle(longint'(lat1), 64), dummy, c1);
        rotate(binary_angle(longint'(lat2), 64), dummy, c2);
        cc = (c1 * c2) >>> 30;
        a = ((s1 * s1) >>> 30) + ((cc * ((s2 * s2) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > ONE_Q30) a = ONE_Q30;
        vy = int_sqrt(longint'(a) << 30);
        vx = int_sqrt((ONE_Q30 - a) << 30);
        z = 0;
        for (int i = 0; i < 30; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; z += atan_steps[i];
            end else begin
                vx -= dx; vy += dy; z -= atan_steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > ONE_Q30) z = ONE_Q30;
        m = longint'(z) * 64'd1686629713;
        cr = (m + (64'd1 << 28)) >> 29;
        d = (longint'(radius) * cr + (64'd1 << 29)) >> 30;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        return d[31:0];
    endfunction

    function void note_pair(logic [127:0] beat);
        pending_dist = {pending_dist, great_circle(beat[30:0], beat[62:31],
                                                   beat[93:63], beat[125:94])};
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        n_errors++;
    endtask

    task check_distance(logic [31:0] got);
        logic [31:0] want;
        if (pending_dist.size() == 0) begin
            report($sformatf("distance %0d arrived with nothing expected", got));
            return;
        end
        want = pending_dist.pop_front();
        if (got !== want)
            report($sformatf("distance got %0d expected %0d", got, want));
    endtask
endclass

module haversine_great_circle_distance_tb;

    localparam int PIPE_LATENCY = 108;
    localparam int STALL_LIMIT  = 4000;

    localparam logic signed [30:0] LAT_MAX = 31'sd754974720;
    localparam logic signed [31:0] LON_MAX = 32'sd1509949440;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [31:0]  o_m_axis_tdata;

    distance_scoreboard board;
    int  idle_cycles;
    bit  timed_out;
    bit  stim_done;

    haversine_great_circle_distance dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 8 ns clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both sides of the handshake are sampled right at the edge, so the
    // monitor sees the same values the block does.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_pair(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_distance(o_m_axis_tdata);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) ||
                (stim_done && board.pending_dist.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver drops ready for a random gap before each beat it takes.
    // Some stretches run with ready held high.
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk iff o_m_axis_tvalid);
        end
    end

    // Sends one coordinate pair after a random gap; valid stays high between
    // back-to-back beats.
    task automatic send_pair(logic signed [30:0] lat1, logic signed [31:0] lon1,
                             logic signed [30:0] lat2, logic signed [31:0] lon2,
                             bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, lon2, lat2, lon1, lat1};
        @(posedge i_clk iff o_s_axis_tready);
    endtask

    // Lets every predicted distance drain, then waits out the pipe.
    task automatic drain_pipe();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_dist.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.radius = value;
    endtask

    function automatic logic signed [30:0] random_lat(bit wide);
        if (wide)
            return 31'($urandom);
        return 31'(int'($urandom_range(0, 2 * LAT_MAX)) - int'(LAT_MAX));
    endfunction

    function automatic logic signed [31:0] random_lon();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return 32'(longint'($urandom_range(0, 32'd3019898880)) - longint'(LON_MAX));
            default: return 32'(int'($urandom_range(0, 32'd200000000)) - 100000000);
        endcase
    endfunction

    // A random pair; close pairs, antipodes and equal points mix with
    // fully random ones.
    task automatic send_random_pair(bit allow_gap);
        logic signed [30:0] la1, la2;
        logic signed [31:0] lo1, lo2;
        la1 = random_lat($urandom_range(0, 9) == 0);
        lo1 = random_lon();
        case ($urandom_range(0, 5))
            0: begin
                la2 = la1 + 31'(int'($urandom_range(0, 2000)) - 1000);
                lo2 = lo1 + 32'(int'($urandom_range(0, 2000)) - 1000);
            end
            1: begin
                la2 = -la1;
                lo2 = lo1 + 32'sd1509949440;
            end
            2: begin
                la2 = la1;
                lo2 = lo1;
            end
            default: begin
                la2 = random_lat($urandom_range(0, 9) == 0);
                lo2 = random_lon();
            end
        endcase
        send_pair(la1, lo1, la2, lo2, allow_gap);
    endtask

    initial begin
        board = new();
        idle_cycles = 0;
        timed_out = 0;
        stim_done = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs at the reset radius: identical points, poles,
        // antipodes, longitude wrap, latitudes beyond ninety degrees and
        // the extreme field codes.
        send_pair(0, 0, 0, 0, 1);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0, 1);
        send_pair(0, 0, 0, LON_MAX, 1);
        send_pair(0, -LON_MAX, 0, LON_MAX, 1);
        send_pair(0, LON_MAX, 0, -LON_MAX + 32'sd8388608, 1);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 1);
        send_pair(-LAT_MAX, 0, -LAT_MAX, 32'sd12345678, 1);
        send_pair(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000, 1);
        send_pair(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_pair(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 1);
        send_pair(31'sd1000000000, 0, -31'sd1000000000, LON_MAX, 1);
        send_pair(31'sd377487360, 32'sd100, 31'sd377487361, 32'sd101, 1);
        send_pair(0, 0, 1, 1, 1);
        send_pair(0, 0, 0, 32'sd754974720, 1);
        drain_pipe();

        // Radius extremes: zero and all ones (saturates).
        write_radius(32'd0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0, 1);
        send_pair(0, 0, 0, 32'sd100000000, 1);
        drain_pipe();
        write_radius(32'hFFFF_FFFF);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0, 1);
        send_pair(0, 0, 0, 32'sd1000, 1);
        send_pair(0, 0, 0, 0, 1);
        drain_pipe();

        // Random phases, each opening with a radius write.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_radius(32'd417530431);
                1: write_radius($urandom);
                2: write_radius(32'hFFFF_FFFF);
                3: write_radius($urandom_range(1, 1000));
                default: write_radius(32'd417530431);
            endcase
            for (int k = 0; k < 350; k++) begin
                // Bursts without gaps every so often.
                send_random_pair((k / 40) % 3 != 2);
                if (k == 175)
                    drain_pipe();
            end
            drain_pipe();
        end

        stim_done = 1;
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_dist.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (!timed_out) begin
            if (board.n_errors == 0 && board.pending_dist.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Watchdog on cycles without any beat accepted.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("timeout waiting for a beat");
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
